// ===== rtl/assert_macros.svh =====
// Assertion helpers included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checks a property on every rising edge of clock outside reset.
`define ASSERT_AT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");

// Checks that an expression never holds.
`define ASSERT_NEVER(label, expr) \
   `ASSERT_AT(label, !(expr))

`else

`define ASSERT_AT(label, prop)
`define ASSERT_NEVER(label, expr)

`endif

`endif

// ===== rtl/chfa_pkg.sv =====
package chfa_pkg;

   localparam int AXIS_W   = 16;
   localparam int VEC_W    = 27;
   localparam int ANG_W    = 27;
   localparam int HEAD_W   = 15;
   localparam int ATAN_LEN = 24;

   // Angles are held in degrees times 65536.
   localparam logic signed [ANG_W-1:0] HALF_TURN  = 27'sd11796480;
   localparam logic signed [ANG_W-1:0] FULL_TURN  = 27'sd23592960;
   localparam logic signed [ANG_W-1:0] ROUND_HALF = 27'sd512;
   localparam logic [HEAD_W-1:0]       HEADING_FULL = 15'd23040;

   typedef struct packed {
      logic signed [AXIS_W-1:0] x_axis;
      logic signed [AXIS_W-1:0] y_axis;
   } req_type;

   typedef struct packed {
      logic [HEAD_W-1:0] heading;
      logic              zero_field;
   } rsp_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [ANG_W-1:0] z;
      logic                    zero;
   } stage_type;

   // atan(2^-i) in degrees times 65536, rounded to nearest.
   function automatic logic signed [ANG_W-1:0] atan_deg(input int idx);
      logic signed [ANG_W-1:0] a;
      case (idx)
         0: begin a = 27'sd2949120; end
         1: begin a = 27'sd1740967; end
         2: begin a = 27'sd919879; end
         3: begin a = 27'sd466945; end
         4: begin a = 27'sd234379; end
         5: begin a = 27'sd117304; end
         6: begin a = 27'sd58666; end
         7: begin a = 27'sd29335; end
         8: begin a = 27'sd14668; end
         9: begin a = 27'sd7334; end
         10: begin a = 27'sd3667; end
         11: begin a = 27'sd1833; end
         12: begin a = 27'sd917; end
         13: begin a = 27'sd458; end
         14: begin a = 27'sd229; end
         15: begin a = 27'sd115; end
         16: begin a = 27'sd57; end
         17: begin a = 27'sd29; end
         18: begin a = 27'sd14; end
         19: begin a = 27'sd7; end
         20: begin a = 27'sd4; end
         21: begin a = 27'sd2; end
         22: begin a = 27'sd1; end
         default: begin a = '0; end
      endcase
      return a;
   endfunction

endpackage

// ===== rtl/compass_heading_from_axes_top.sv =====
// Compass heading from the X and Y magnetometer axes: each word gives the
// heading atan2(Y, X) in degrees times 64, 0 to 23039, with zero_field set
// and heading 0 when both axes are zero. The angle comes from an unrolled
// vectoring CORDIC with one register stage per iteration, behind a stage
// that folds the vector into the right half plane and ahead of a stage that
// wraps and rounds the angle. A word enters every cycle unless rsp_ready
// holds the pipeline back. An idle stage takes a new word even while the
// result register waits on rsp_ready, so bubbles close up during a stall.
`include "assert_macros.svh"

module compass_heading_from_axes_top #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  chfa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output chfa_pkg::rsp_type rsp_data
);
   import chfa_pkg::*;

   localparam int STEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

   stage_type        stg_ff [0:STEPS];
   stage_type        stg_in [0:STEPS];
   logic [STEPS:0]   vld_ff;
   logic [STEPS:0]   adv;
   logic             out_vld_ff;
   logic             out_adv;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;

   logic signed [VEC_W-1:0] pre_x;
   logic signed [VEC_W-1:0] pre_y;

   // Fold a left-half-plane vector by 180 degrees.
   always_comb begin
      pre_x = {{(VEC_W-AXIS_W-8){req_data.x_axis[AXIS_W-1]}}, req_data.x_axis, 8'b0};
      pre_y = {{(VEC_W-AXIS_W-8){req_data.y_axis[AXIS_W-1]}}, req_data.y_axis, 8'b0};
      stg_in[0].zero = (req_data.x_axis == '0) && (req_data.y_axis == '0);
      if (pre_x < 0) begin
         stg_in[0].x = -pre_x;
         stg_in[0].y = -pre_y;
         stg_in[0].z = HALF_TURN;
      end else begin
         stg_in[0].x = pre_x;
         stg_in[0].y = pre_y;
         stg_in[0].z = '0;
      end
   end

   assign out_adv   = !out_vld_ff || rsp_ready;
   assign req_ready = adv[0];

   genvar k;
   generate
      for (k = 1; k <= STEPS; k++) begin : g_cordic
         logic signed [VEC_W-1:0] cur_x;
         logic signed [VEC_W-1:0] cur_y;
         logic signed [VEC_W-1:0] dx;
         logic signed [VEC_W-1:0] dy;

         always_comb begin
            cur_x = stg_ff[k-1].x;
            cur_y = stg_ff[k-1].y;
            dx = cur_y >>> (k-1);
            dy = cur_x >>> (k-1);
            stg_in[k].zero = stg_ff[k-1].zero;
            if (cur_y >= 0) begin
               stg_in[k].x = cur_x + dx;
               stg_in[k].y = cur_y - dy;
               stg_in[k].z = stg_ff[k-1].z + atan_deg(k-1);
            end else begin
               stg_in[k].x = cur_x - dx;
               stg_in[k].y = cur_y + dy;
               stg_in[k].z = stg_ff[k-1].z - atan_deg(k-1);
            end
         end
      end

      for (k = 0; k <= STEPS; k++) begin : g_stage
         // A stage moves when it is empty or its successor moves.
         if (k == STEPS) begin : g_last
            assign adv[k] = !vld_ff[k] || out_adv;
         end else begin : g_mid
            assign adv[k] = !vld_ff[k] || adv[k+1];
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[k] <= 1'b0;
            end else if (adv[k]) begin
               vld_ff[k] <= (k == 0) ? req_valid : vld_ff[(k == 0) ? 0 : k-1];
            end
         end

         always_ff @(posedge clock) begin
            if (adv[k]) begin
               stg_ff[k] <= stg_in[k];
            end
         end
      end
   endgenerate

   logic signed [ANG_W-1:0] z_rnd;
   logic [HEAD_W-1:0]       h_raw;

   // Wrap into [0, 360) and round to 6 fractional bits with one add, then fold a rounded 360 back to 0.
   always_comb begin
      z_rnd = stg_ff[STEPS].z +
              ((stg_ff[STEPS].z < 0) ? FULL_TURN + ROUND_HALF : ROUND_HALF);
      h_raw = z_rnd[HEAD_W+9:10];
      if (stg_ff[STEPS].zero) begin
         rsp_in.heading = '0;
      end else if (h_raw >= HEADING_FULL) begin
         rsp_in.heading = h_raw - HEADING_FULL;
      end else begin
         rsp_in.heading = h_raw;
      end
      rsp_in.zero_field = stg_ff[STEPS].zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_adv) begin
         out_vld_ff <= vld_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_AT(a_accept_lands, req_valid && req_ready |=> vld_ff[0])
   `ASSERT_AT(a_empty_ready, (vld_ff == '0) && !out_vld_ff |-> req_ready)
   `ASSERT_NEVER(a_heading_range, rsp_valid && (rsp_data.heading >= HEADING_FULL))
   `ASSERT_NEVER(a_zero_heading, rsp_valid && rsp_data.zero_field && (rsp_data.heading != '0))

endmodule

// ===== bench/tb_compass_heading_from_axes_top.sv =====
`timescale 1ns / 1ps

module tb_compass_heading_from_axes_top;

   import chfa_pkg::*;

   localparam int CORDIC_STEPS = 16;
   localparam int ITERATIONS   = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
   localparam int LATENCY      = ITERATIONS + 2;
   localparam int RANDOM_WORDS = 1250;
   localparam int QUIET_WORDS  = 150;
   localparam int LONG_HOLD    = 400;
   localparam int CYCLE_LIMIT  = 200000;
   localparam longint DEG_Q16  = 65536;

   typedef struct {
      req_type word;
      bit      typed;
      rsp_type result;
   } bearing_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // Expectation that travels with the word on the input side.
   logic    row_typed;
   rsp_type row_result;

   rsp_type         heading_q[$];
   bearing_row_type bearing_rows[$];
   int              mismatches = 0;
   int              words_in = 0;
   bit              quiet = 1'b0;
   bit              hold_done = 1'b0;

   // atan(2^-i) in degrees with 16 fractional bits.
   longint arctan_q16 [0:23] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   compass_heading_from_axes_top #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic rsp_type predict_heading(req_type w);
      longint  vx;
      longint  vy;
      longint  ang;
      longint  sx;
      longint  sy;
      longint  rounded;
      rsp_type r;
      vx = longint'(w.x_axis);
      vy = longint'(w.y_axis);
      ang = 0;
      r = '0;
      if (vx == 0 && vy == 0) begin
         r.zero_field = 1'b1;
         return r;
      end
      vx = vx * 256;
      vy = vy * 256;
      // Fold the left half plane over so the iterations always converge.
      if (vx < 0) begin
         vx = -vx;
         vy = -vy;
         ang = 180 * DEG_Q16;
      end
      for (int i = 0; i < ITERATIONS; i++) begin
         sx = vy >>> i;
         sy = vx >>> i;
         if (vy >= 0) begin
            vx = vx + sx;
            vy = vy - sy;
            ang = ang + arctan_q16[i];
         end else begin
            vx = vx - sx;
            vy = vy + sy;
            ang = ang - arctan_q16[i];
         end
      end
      if (ang < 0) begin
         ang = ang + 360 * DEG_Q16;
      end
      rounded = (ang + 512) >>> 10;
      if (rounded >= 360 * 64) begin
         rounded = rounded - 360 * 64;
      end
      r.heading = rounded[HEAD_W-1:0];
      return r;
   endfunction

   function automatic logic signed [AXIS_W-1:0] pick_extreme();
      case ($urandom_range(0, 4))
         0: begin return -16'sd32768; end
         1: begin return -16'sd1; end
         2: begin return 16'sd0; end
         3: begin return 16'sd1; end
         default: begin return 16'sd32767; end
      endcase
   endfunction

   function automatic req_type random_sample();
      req_type w;
      int      a;
      int      b;
      a = int'($urandom_range(0, 64)) - 32;
      b = int'($urandom_range(0, 4)) - 2;
      w.x_axis = 16'($urandom());
      w.y_axis = 16'($urandom());
      case ($urandom_range(0, 9))
         4, 5: begin
            w.x_axis = a[15:0];
            w.y_axis = 16'(int'($urandom_range(0, 64)) - 32);
         end
         6: begin
            // Close to an axis, where the wrap at 360 degrees shows up.
            if ($urandom_range(0, 1) == 1) begin
               w.y_axis = b[15:0];
            end else begin
               w.x_axis = b[15:0];
            end
         end
         7: begin
            w.x_axis = pick_extreme();
            w.y_axis = pick_extreme();
         end
         8: begin
            w.y_axis = ($urandom_range(0, 1) == 1) ? w.x_axis : -w.x_axis;
         end
         9: begin
            if ($urandom_range(0, 2) == 0) begin
               w = '0;
            end
         end
         default: begin
         end
      endcase
      return w;
   endfunction

   task automatic add_row(input int x, input int y, input bit typed,
                          input int heading, input bit zero);
      bearing_row_type row;
      row.word.x_axis    = x[15:0];
      row.word.y_axis    = y[15:0];
      row.typed          = typed;
      row.result.heading = heading[HEAD_W-1:0];
      row.result.zero_field = zero;
      bearing_rows.push_back(row);
   endtask

   task automatic send_word(input req_type w, input bit typed, input rsp_type result);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_data   <= w;
      row_typed  <= typed;
      row_result <= result;
      do @(posedge clock); while (!req_ready);
   endtask

   // Scoreboard: results are popped before the new word is pushed.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (heading_q.size() == 0) begin
               $error("result word with no expectation pending: heading %0d zero_field %0d",
                      rsp_data.heading, rsp_data.zero_field);
               mismatches++;
            end else begin
               want = heading_q.pop_front();
               if (rsp_data.heading !== want.heading) begin
                  $error("heading: expected %0d, got %0d", want.heading, rsp_data.heading);
                  mismatches++;
               end
               if (rsp_data.zero_field !== want.zero_field) begin
                  $error("zero_field: expected %0d, got %0d",
                         want.zero_field, rsp_data.zero_field);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            heading_q.push_back(row_typed ? row_result : predict_heading(req_data));
            words_in++;
         end
      end
   end

   // Result side: random stalls, plus one long hold-off that backs the pipeline up.
   initial begin
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!reset && !hold_done && words_in >= 150) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_done = 1'b1;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb_compass_heading_from_axes_top: FAIL");
      $finish;
   end

   initial begin
      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_data   <= '0;
      row_typed  <= 1'b0;
      row_result <= '0;

      add_row(0, 0, 1'b1, 0, 1'b1);
      add_row(1, 0, 1'b0, 0, 1'b0);
      add_row(0, 1, 1'b0, 0, 1'b0);
      add_row(-1, 0, 1'b0, 0, 1'b0);
      add_row(0, -1, 1'b0, 0, 1'b0);
      add_row(32767, 0, 1'b0, 0, 1'b0);
      add_row(-32768, 0, 1'b0, 0, 1'b0);
      add_row(0, 32767, 1'b0, 0, 1'b0);
      add_row(0, -32768, 1'b0, 0, 1'b0);
      add_row(32767, 32767, 1'b0, 0, 1'b0);
      add_row(-32768, -32768, 1'b0, 0, 1'b0);
      add_row(32767, -32768, 1'b0, 0, 1'b0);
      add_row(-32768, 32767, 1'b0, 0, 1'b0);
      add_row(1, 1, 1'b0, 0, 1'b0);
      add_row(1, -1, 1'b0, 0, 1'b0);
      add_row(-1, 1, 1'b0, 0, 1'b0);
      add_row(-1, -1, 1'b0, 0, 1'b0);
      add_row(32767, -1, 1'b0, 0, 1'b0);
      add_row(32767, 1, 1'b0, 0, 1'b0);
      add_row(-32768, 1, 1'b0, 0, 1'b0);
      add_row(-32768, -1, 1'b0, 0, 1'b0);
      add_row(-21846, 21845, 1'b0, 0, 1'b0);
      add_row(0, 0, 1'b1, 0, 1'b1);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int k = 0; k < bearing_rows.size(); k++) begin
         send_word(bearing_rows[k].word, bearing_rows[k].typed, bearing_rows[k].result);
      end
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == RANDOM_WORDS - QUIET_WORDS) begin
            quiet = 1'b1;
         end
         send_word(random_sample(), 1'b0, '0);
      end
      req_valid <= 1'b0;
      @(posedge clock);

      while (heading_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);

      if (mismatches == 0 && heading_q.size() == 0) begin
         $display("tb_compass_heading_from_axes_top: PASS");
      end else begin
         $display("tb_compass_heading_from_axes_top: FAIL");
      end
      $finish;
   end

endmodule
